@@ rtl/aawh_pkg.sv @@
package aawh_pkg;

	localparam logic [1:0] MODE_ARC    = 2'd0;
	localparam logic [1:0] MODE_ROW    = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int LINEAR_LIMIT = 10;

	localparam int ENTRY_BITS  = 14;
	localparam int FIELD_SYM   = 16;
	localparam int FIELD_TGT   = 12;
	localparam int FIELD_WGT   = 24;
	localparam int FIELD_COUNT = 15;
	localparam int FIELD_INDEX = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_PROBE,
		ST_CHECK,
		ST_FINAL,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [ENTRY_BITS-1:0] entry_index;
		logic [FIELD_SYM-1:0]  arc_symbol;
		logic [FIELD_TGT-1:0]  arc_target;
		logic [FIELD_WGT-1:0]  arc_weight;
		logic [ENTRY_BITS-1:0] row_first;
		logic [FIELD_COUNT-1:0] row_count;
		logic                  row_final;
		logic [FIELD_SYM-1:0]  lookup_symbol;
		logic                  last_symbol;
	} item_t;

	typedef struct packed {
		logic                   accepted;
		logic                   is_prefix;
		logic [FIELD_INDEX-1:0] hash_index;
		logic                   hash_saturated;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item, perform writes
		logic row_rd;     // read row of current state
		logic search_init;
		logic probe_rd;   // read arc at probe position
		logic take_arc;   // apply matched arc
		logic fail;
		logic final_rd;   // read row of target
		logic apply_final;
		logic finish;     // build result and reset walk
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;       // row memory still clearing after reset
		logic is_lookup;
		logic is_last;
		logic walk_failed;
		logic row_empty;
		logic hit;
		logic search_done;
	} dp_stat_t;

endpackage

@@ rtl/aawh_if.sv @@
interface aawh_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/aawh_ctrl.sv @@
module aawh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  aawh_pkg::dp_stat_t stat,
	output aawh_pkg::dp_cmd_t  cmd
);

	aawh_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= aawh_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// sequence one item: a write, or for a lookup symbol row read, arc probes, target row read, result
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			aawh_pkg::ST_IDLE: begin
				// hold off input while the row memory clears
				in_ready = !stat.busy;
				if (in_valid && !stat.busy) begin
					cmd.load = 1'b1;
					state_d  = aawh_pkg::ST_ROW;
				end
			end
			aawh_pkg::ST_ROW: begin
				if (!stat.is_lookup) state_d = aawh_pkg::ST_IDLE;
				else if (stat.walk_failed) begin
					if (stat.is_last) begin
						cmd.finish = 1'b1;
						state_d    = aawh_pkg::ST_EMIT;
					end else state_d = aawh_pkg::ST_IDLE;
				end else begin
					cmd.row_rd = 1'b1;
					state_d    = aawh_pkg::ST_PROBE;
				end
			end
			aawh_pkg::ST_PROBE: begin
				if (stat.row_empty) begin
					cmd.fail = 1'b1;
					state_d  = aawh_pkg::ST_FINAL;
				end else begin
					cmd.search_init = 1'b1;
					cmd.probe_rd    = 1'b1;
					state_d         = aawh_pkg::ST_CHECK;
				end
			end
			aawh_pkg::ST_CHECK: begin
				if (stat.hit) begin
					cmd.take_arc = 1'b1;
					cmd.final_rd = 1'b1;
					state_d      = aawh_pkg::ST_FINAL;
				end else if (stat.search_done) begin
					cmd.fail = 1'b1;
					state_d  = aawh_pkg::ST_FINAL;
				end else cmd.probe_rd = 1'b1;
			end
			aawh_pkg::ST_FINAL: begin
				cmd.apply_final = 1'b1;
				if (stat.is_last) begin
					cmd.finish = 1'b1;
					state_d    = aawh_pkg::ST_EMIT;
				end else state_d = aawh_pkg::ST_IDLE;
			end
			aawh_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = aawh_pkg::ST_IDLE;
			end
			default: state_d = aawh_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/aawh_dp.sv @@
module aawh_dp #(
	parameter int MAX_STATES  = 4096,
	parameter int MAX_ARCS    = 16384,
	parameter int SYMBOL_BITS = 16,
	parameter int INDEX_BITS  = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aawh_pkg::item_t    item,
	input  aawh_pkg::dp_cmd_t  cmd,
	output aawh_pkg::dp_stat_t stat,
	output aawh_pkg::result_t  result
);

	localparam int SB = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int AB = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
	localparam int PB = AB + 1;
	localparam int CLR_BITS = SB + 1;
	localparam int ARC_W = SYMBOL_BITS + aawh_pkg::FIELD_TGT + aawh_pkg::FIELD_WGT;
	localparam int ROW_W = aawh_pkg::ENTRY_BITS + aawh_pkg::FIELD_COUNT + 1;
	localparam logic [INDEX_BITS:0] IDX_MAX = {1'b0, {INDEX_BITS{1'b1}}};

	logic [ARC_W-1:0] arc_mem [MAX_ARCS];
	logic [ROW_W-1:0] row_mem [MAX_STATES];
	logic [ARC_W-1:0] arc_rd_q;
	logic [ROW_W-1:0] row_rd_q;

	aawh_pkg::item_t     item_q;
	logic [SB-1:0]       walk_q;
	logic                walk_big_q;  // current state beyond the store
	logic [INDEX_BITS-1:0] idx_q;
	logic                sat_q, failed_q;
	logic [PB-1:0]       lo_q, hi_q, probe_q;
	logic                linear_q;
	logic                tgt_big_q;
	logic [PB-1:0]       lo_n, hi_n, mid, probe_d;
	logic                done_n;

	// row memory clearing sweep after reset
	logic [CLR_BITS-1:0] clr_q;
	logic                clearing;
	assign clearing = (clr_q < CLR_BITS'(MAX_STATES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + CLR_BITS'(1);
	end

	assign stat.busy = clearing;

	// write index range checks against the store geometry
	logic arc_ok, row_ok;
	assign arc_ok = (32'(item.entry_index) < 32'(MAX_ARCS));
	assign row_ok = (32'(item.entry_index) < 32'(MAX_STATES));

	// row read address: current state on row_rd, target on final_rd
	logic [aawh_pkg::FIELD_TGT-1:0] arc_tgt;
	assign arc_tgt = arc_rd_q[aawh_pkg::FIELD_WGT +: aawh_pkg::FIELD_TGT];
	logic tgt_big;
	assign tgt_big = ({20'd0, arc_tgt} >= 32'(MAX_STATES));

	always_ff @(posedge clk) begin
		if (clearing) row_mem[clr_q[SB-1:0]] <= '0;
		else if (cmd.load && item.mode == aawh_pkg::MODE_ROW && row_ok)
			row_mem[SB'(item.entry_index)] <= {item.row_first, item.row_count, item.row_final};
		if (cmd.row_rd) row_rd_q <= row_mem[walk_q];
		else if (cmd.final_rd) row_rd_q <= row_mem[SB'(arc_tgt)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && item.mode == aawh_pkg::MODE_ARC && arc_ok)
			arc_mem[AB'(item.entry_index)] <= {SYMBOL_BITS'(item.arc_symbol),
				item.arc_target, item.arc_weight};
		if (cmd.probe_rd) arc_rd_q <= arc_mem[probe_d[AB-1:0]];
	end

	// row bounds
	logic [aawh_pkg::ENTRY_BITS-1:0]  r_first;
	logic [aawh_pkg::FIELD_COUNT-1:0] r_count;
	assign r_first = row_rd_q[ROW_W-1 -: aawh_pkg::ENTRY_BITS];
	assign r_count = row_rd_q[1 +: aawh_pkg::FIELD_COUNT];
	logic [31:0] lo_w, hi_w, end_w;
	assign lo_w  = 32'(r_first);
	assign end_w = lo_w + 32'(r_count);
	assign hi_w  = (end_w > 32'(MAX_ARCS)) ? 32'(MAX_ARCS) : end_w;
	assign stat.row_empty = walk_big_q || (lo_w >= hi_w);

	// probe comparison
	logic [SYMBOL_BITS-1:0] p_sym, l_sym;
	assign p_sym = arc_rd_q[ARC_W-1 -: SYMBOL_BITS];
	assign l_sym = SYMBOL_BITS'(item_q.lookup_symbol);
	logic eq, less;
	assign eq   = (p_sym == l_sym);
	assign less = (p_sym < l_sym);

	// next bounds of the search after the current probe
	always_comb begin
		lo_n   = lo_q;
		hi_n   = hi_q;   // hi exclusive
		done_n = 1'b0;
		if (linear_q) begin
			lo_n   = probe_q + PB'(1);
			done_n = (lo_n >= hi_q);
		end else begin
			if (less) lo_n = probe_q + PB'(1);
			else hi_n = probe_q;
			done_n = (lo_n >= hi_n);
		end
		// midpoint rounds down over the inclusive range lo .. hi-1
		mid = lo_n + ((hi_n - lo_n - PB'(1)) >> 1);
		if (cmd.search_init) begin
			lo_n    = PB'(lo_w);
			hi_n    = PB'(hi_w);
			probe_d = (hi_w - lo_w <= 32'(aawh_pkg::LINEAR_LIMIT)) ? PB'(lo_w) :
				PB'(lo_w + ((hi_w - lo_w - 32'd1) >> 1));
		end else probe_d = linear_q ? lo_n : mid;
	end
	assign stat.hit         = eq;
	assign stat.search_done = done_n;

	// weight accumulation
	logic [INDEX_BITS:0] sum_w;
	assign sum_w = {1'b0, idx_q} + (INDEX_BITS+1)'(arc_rd_q[aawh_pkg::FIELD_WGT-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q     <= '0;
			walk_big_q <= 1'b0;
			idx_q      <= '0;
			sat_q      <= 1'b0;
			failed_q   <= 1'b0;
			linear_q   <= 1'b0;
			tgt_big_q  <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			probe_q    <= '0;
		end else begin
			if (cmd.search_init) linear_q <= (hi_w - lo_w <= 32'(aawh_pkg::LINEAR_LIMIT));
			if (cmd.probe_rd) begin
				lo_q    <= lo_n;
				hi_q    <= hi_n;
				probe_q <= probe_d;
			end
			if (cmd.fail) failed_q <= 1'b1;
			if (cmd.take_arc) begin
				walk_q     <= SB'(arc_tgt);
				walk_big_q <= tgt_big;
				tgt_big_q  <= tgt_big;
				if (sum_w > IDX_MAX) begin
					idx_q <= IDX_MAX[INDEX_BITS-1:0];
					sat_q <= 1'b1;
				end else idx_q <= sum_w[INDEX_BITS-1:0];
			end
			// add one when the reached state is final
			if (cmd.apply_final && !cmd.finish && !failed_q && !cmd.fail && !tgt_big_q &&
				row_rd_q[0]) begin
				if (idx_q == IDX_MAX[INDEX_BITS-1:0]) sat_q <= 1'b1;
				else idx_q <= idx_q + INDEX_BITS'(1);
			end
			if (cmd.finish) begin
				walk_q     <= '0;
				walk_big_q <= 1'b0;
				idx_q      <= '0;
				sat_q      <= 1'b0;
				failed_q   <= 1'b0;
			end
			if (cmd.apply_final) tgt_big_q <= 1'b0;
		end
	end

	// final mark of the walk state, tracked across symbols
	logic fin_q, fin_now;
	assign fin_now = !tgt_big_q && row_rd_q[0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_q <= 1'b0;
		else if (cmd.finish) fin_q <= 1'b0;
		else if (cmd.apply_final && !cmd.fail && !failed_q) fin_q <= fin_now;
	end

	// result register
	logic pre, acc, fin_res;
	assign fin_res = (cmd.apply_final) ? fin_now : fin_q;
	assign pre = !failed_q && !cmd.fail;
	assign acc = pre && fin_res && !(walk_big_q && !cmd.apply_final);
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.finish) begin
			result.accepted       <= acc;
			result.is_prefix      <= pre;
			result.hash_index     <= acc ? aawh_pkg::FIELD_INDEX'(
				(cmd.apply_final && fin_now && idx_q != IDX_MAX[INDEX_BITS-1:0]) ?
				idx_q + INDEX_BITS'(1) : idx_q) : '0;
			result.hash_saturated <= acc && (sat_q ||
				(cmd.apply_final && fin_now && idx_q == IDX_MAX[INDEX_BITS-1:0]));
		end
	end

	assign stat.is_lookup   = (item_q.mode == aawh_pkg::MODE_LOOKUP);
	assign stat.is_last     = item_q.last_symbol;
	assign stat.walk_failed = failed_q;

endmodule

@@ rtl/acyclic_automaton_word_hash.sv @@
// Weighted acyclic automaton word hash.
// Channel "in" carries aawh_pkg::item_t: mode 0 writes an arc slot, mode 1
// writes a state row, mode 2 feeds one symbol of a word to look up.
// Channel "out" carries aawh_pkg::result_t, one transaction per word, on the
// symbol marked last: accepted, is_prefix, hash_index and hash_saturated.
// Items are handled one at a time. A lookup symbol reads the row of the
// current state and probes its arcs: the arc memory read port allows one
// probe a cycle, up to 10 probes for short rows scanned linearly and about
// log2(fanout) probes for longer rows searched by bisection. Once the walk
// has failed, the remaining symbols of the word skip the row read and the
// probes. After the last symbol the result is presented on out.
// After reset the row memory is cleared, one row a cycle over all
// MAX_STATES rows; the input is not ready until that sweep ends. The walk
// restarts at state 0 after reset and after each word.
// While the receiver stalls the result is held and no new item is taken.
module acyclic_automaton_word_hash #(
	parameter int MAX_STATES  = 4096,
	parameter int MAX_ARCS    = 16384,
	parameter int SYMBOL_BITS = 16,
	parameter int INDEX_BITS  = 24
) (
	input logic  clk,
	input logic  arst_n,
	aawh_if.sink   in,
	aawh_if.source out
);

	aawh_pkg::dp_cmd_t  cmd;
	aawh_pkg::dp_stat_t stat;
	aawh_pkg::item_t    item;
	aawh_pkg::result_t  result;

	assign item        = aawh_pkg::item_t'(in.payload);
	assign out.payload = result;

	aawh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aawh_dp #(
		.MAX_STATES  (MAX_STATES),
		.MAX_ARCS    (MAX_ARCS),
		.SYMBOL_BITS (SYMBOL_BITS),
		.INDEX_BITS  (INDEX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule
